// ----- hw/rtl/fsg_pkg.sv -----
// Shared types and constants for the falling sand grid block.
`timescale 1ns / 1ps
package fsg_pkg;

   localparam int COORD_W = 12;

   localparam logic [1:0] KIND_PAINT = 2'd0;
   localparam logic [1:0] KIND_SWEEP = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [2:0] MAT_EMPTY = 3'd0;
   localparam logic [2:0] MAT_SAND  = 3'd1;

   localparam logic [15:0] LFSR_TAPS   = 16'hB400;
   localparam logic [7:0]  BRUSH_RESET = 8'd64;
   localparam logic [15:0] SEED_RESET  = 16'd1;

   localparam logic CSR_BRUSH_SIZE  = 1'b0;
   localparam logic CSR_RANDOM_SEED = 1'b1;

   typedef enum logic [1:0] {
      OP_PAINT,
      OP_SWEEP,
      OP_READ,
      OP_NONE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic               in_grid;
      logic [2:0]         material;
      logic [COORD_W-1:0] x_lo;
      logic [COORD_W-1:0] x_hi;
      logic [COORD_W-1:0] y_lo;
      logic [COORD_W-1:0] y_hi;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAINT,
      ST_READ,
      ST_READ_WAIT,
      ST_SCAN,
      ST_HERE,
      ST_BELOW,
      ST_DIAG,
      ST_MOVE,
      ST_DONE
   } back_state_type;

endpackage

// ----- hw/rtl/fsg_req_if.sv -----
// Input item channel carrying grid commands.
`timescale 1ns / 1ps
interface fsg_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] x_pos;
   logic [7:0] y_pos;
   logic [2:0] material;

   modport source (output valid, kind, x_pos, y_pos, material, input ready);
   modport sink (input valid, kind, x_pos, y_pos, material, output ready);
endinterface

// ----- hw/rtl/fsg_rsp_if.sv -----
// Result item channel carrying grid command results.
`timescale 1ns / 1ps
interface fsg_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cell_material;
   logic [15:0] grains_moved;

   modport source (output valid, cell_material, grains_moved, input ready);
   modport sink (input valid, cell_material, grains_moved, output ready);
endinterface

// ----- hw/rtl/fsg_front.sv -----
// Front end: accepts items, decodes the kind and clips the brush box to the grid.
`timescale 1ns / 1ps
module fsg_front
   import fsg_pkg::*;
#(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256
) (
   fsg_req_if.sink        req_ch,
   input  logic [7:0]     brush_size,
   input  back_status_type status,
   input  logic           queue_full,
   output logic           push,
   output cmd_type        cmd
);

   localparam logic [COORD_W:0] X_MAX = (COORD_W+1)'(GRID_WIDTH - 1);
   localparam logic [COORD_W:0] Y_MAX = (COORD_W+1)'(GRID_HEIGHT - 1);

   logic [COORD_W:0] half;
   logic [COORD_W:0] x_full;
   logic [COORD_W:0] y_full;
   logic [COORD_W:0] x_sum;
   logic [COORD_W:0] y_sum;
   logic [COORD_W:0] x_lo;
   logic [COORD_W:0] x_hi;
   logic [COORD_W:0] y_lo;
   logic [COORD_W:0] y_hi;

   assign req_ch.ready = !queue_full && !status.clearing;
   assign push         = req_ch.valid && req_ch.ready;

   always_comb begin
      half   = (COORD_W+1)'(brush_size[7:1]);
      x_full = (COORD_W+1)'(req_ch.x_pos);
      y_full = (COORD_W+1)'(req_ch.y_pos);
      x_sum  = x_full + half;
      y_sum  = y_full + half;
      x_lo   = (x_full >= half) ? (x_full - half) : '0;
      y_lo   = (y_full >= half) ? (y_full - half) : '0;
      x_hi   = (x_sum > X_MAX) ? X_MAX : x_sum;
      y_hi   = (y_sum > Y_MAX) ? Y_MAX : y_sum;

      cmd          = '0;
      cmd.material = req_ch.material;
      unique case (req_ch.kind)
         KIND_PAINT: begin
            cmd.op      = OP_PAINT;
            cmd.in_grid = (x_lo <= x_hi) && (y_lo <= y_hi);
            cmd.x_lo    = x_lo[COORD_W-1:0];
            cmd.x_hi    = x_hi[COORD_W-1:0];
            cmd.y_lo    = y_lo[COORD_W-1:0];
            cmd.y_hi    = y_hi[COORD_W-1:0];
         end
         KIND_SWEEP: begin
            cmd.op = OP_SWEEP;
         end
         KIND_READ: begin
            cmd.op      = OP_READ;
            cmd.in_grid = (x_full <= X_MAX) && (y_full <= Y_MAX);
            cmd.x_lo    = x_full[COORD_W-1:0];
            cmd.y_lo    = y_full[COORD_W-1:0];
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/fsg_queue.sv -----
// Two-entry command queue between the front end and the grid engine.
`timescale 1ns / 1ps
module fsg_queue
   import fsg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/fsg_back.sv -----
// Grid engine: cell memory, clearing pass, paint, read and the sand sweep sequencer.
`timescale 1ns / 1ps
module fsg_back
   import fsg_pkg::*;
#(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  cmd_type         cmd,
   output logic            pop,
   input  logic            seed_load,
   input  logic [15:0]     seed_value,
   output back_status_type status,
   fsg_rsp_if.source       rsp_ch
);

   localparam int XW        = $clog2(GRID_WIDTH);
   localparam int YW        = $clog2(GRID_HEIGHT);
   localparam int AW        = XW + YW;
   localparam int MEM_DEPTH = 1 << AW;
   localparam logic [XW-1:0] X_LAST  = XW'(GRID_WIDTH - 1);
   localparam logic [YW-1:0] Y_START = YW'(GRID_HEIGHT - 2);

   back_state_type state_ff;
   back_state_type state_in;

   logic [2:0]    mem [MEM_DEPTH];
   logic [2:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [2:0]    wr_data;

   cmd_type       cmd_ff;
   cmd_type       cmd_in;
   logic [XW-1:0] x_ff;
   logic [XW-1:0] x_in;
   logic [YW-1:0] y_ff;
   logic [YW-1:0] y_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic [15:0]   lfsr_ff;
   logic [15:0]   lfsr_in;
   logic          dir_ff;
   logic          dir_in;
   logic [15:0]   grains_ff;
   logic [15:0]   grains_in;
   logic [2:0]    cell_ff;
   logic [2:0]    cell_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [2:0]    out_cell_ff;
   logic [2:0]    out_cell_in;
   logic [15:0]   out_grains_ff;
   logic [15:0]   out_grains_in;

   logic [YW-1:0] y_below;
   logic [XW-1:0] x_right;
   logic [XW-1:0] x_left;
   logic          at_right;
   logic          at_left;
   logic          last_cell;
   logic          paint_row_end;
   logic          paint_last;
   logic          diag_ok;
   logic          out_free;
   logic          clear_last;
   logic [15:0]   lfsr_step;

   assign y_below       = y_ff + YW'(1);
   assign x_right       = x_ff + XW'(1);
   assign x_left        = x_ff - XW'(1);
   assign at_right      = x_ff == X_LAST;
   assign at_left       = x_ff == '0;
   assign last_cell     = at_right && (y_ff == '0);
   assign paint_row_end = x_ff == cmd_ff.x_hi[XW-1:0];
   assign paint_last    = paint_row_end && (y_ff == cmd_ff.y_hi[YW-1:0]);
   assign diag_ok       = lfsr_ff[0] ? !at_left : !at_right;
   assign out_free      = !out_valid_ff || rsp_ch.ready;
   assign clear_last    = &clr_addr_ff;
   assign lfsr_step     = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);

   assign status.clearing = state_ff == ST_CLEAR;
   assign status.idle     = state_ff == ST_IDLE;

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.cell_material = out_cell_ff;
   assign rsp_ch.grains_moved  = out_grains_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_PAINT: state_in = cmd.in_grid ? ST_PAINT : ST_DONE;
                  OP_SWEEP: state_in = ST_SCAN;
                  OP_READ:  state_in = cmd.in_grid ? ST_READ : ST_DONE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_PAINT: begin
            if (paint_last) state_in = ST_DONE;
         end
         ST_READ:      state_in = ST_READ_WAIT;
         ST_READ_WAIT: state_in = ST_DONE;
         ST_SCAN:      state_in = ST_HERE;
         ST_HERE: begin
            if (rd_data_ff == MAT_SAND) begin
               state_in = ST_BELOW;
            end else begin
               state_in = last_cell ? ST_DONE : ST_SCAN;
            end
         end
         ST_BELOW: begin
            if (rd_data_ff == MAT_EMPTY) begin
               state_in = ST_MOVE;
            end else if (diag_ok) begin
               state_in = ST_DIAG;
            end else begin
               state_in = last_cell ? ST_DONE : ST_SCAN;
            end
         end
         ST_DIAG: begin
            if (rd_data_ff == MAT_EMPTY) begin
               state_in = ST_MOVE;
            end else begin
               state_in = last_cell ? ST_DONE : ST_SCAN;
            end
         end
         ST_MOVE: state_in = last_cell ? ST_DONE : ST_SCAN;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      rd_addr       = {y_ff, x_ff};
      wr_en         = 1'b0;
      wr_addr       = {y_ff, x_ff};
      wr_data       = MAT_EMPTY;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      clr_addr_in   = clr_addr_ff;
      lfsr_in       = lfsr_ff;
      dir_in        = dir_ff;
      grains_in     = grains_ff;
      cell_in       = cell_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_cell_in   = out_cell_ff;
      out_grains_in = out_grains_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               pop       = 1'b1;
               cmd_in    = cmd;
               grains_in = '0;
               cell_in   = MAT_EMPTY;
               if (cmd.op == OP_SWEEP) begin
                  x_in = '0;
                  y_in = Y_START;
               end else begin
                  x_in = cmd.x_lo[XW-1:0];
                  y_in = cmd.y_lo[YW-1:0];
               end
            end
         end
         ST_PAINT: begin
            wr_en   = 1'b1;
            wr_data = cmd_ff.material;
            if (paint_row_end) begin
               x_in = cmd_ff.x_lo[XW-1:0];
               y_in = y_ff + YW'(1);
            end else begin
               x_in = x_right;
            end
         end
         ST_READ: begin
         end
         ST_READ_WAIT: begin
            cell_in = rd_data_ff;
         end
         ST_SCAN: begin
         end
         ST_HERE: begin
            if (rd_data_ff == MAT_SAND) begin
               rd_addr = {y_below, x_ff};
            end else begin
               x_in = at_right ? '0 : x_right;
               y_in = at_right ? y_ff - YW'(1) : y_ff;
            end
         end
         ST_BELOW: begin
            if (rd_data_ff == MAT_EMPTY) begin
               wr_en   = 1'b1;
               wr_addr = {y_below, x_ff};
               wr_data = MAT_SAND;
            end else begin
               lfsr_in = lfsr_step;
               dir_in  = lfsr_ff[0];
               rd_addr = {y_below, lfsr_ff[0] ? x_left : x_right};
               if (!diag_ok) begin
                  x_in = at_right ? '0 : x_right;
                  y_in = at_right ? y_ff - YW'(1) : y_ff;
               end
            end
         end
         ST_DIAG: begin
            if (rd_data_ff == MAT_EMPTY) begin
               wr_en   = 1'b1;
               wr_addr = {y_below, dir_ff ? x_left : x_right};
               wr_data = MAT_SAND;
            end else begin
               x_in = at_right ? '0 : x_right;
               y_in = at_right ? y_ff - YW'(1) : y_ff;
            end
         end
         ST_MOVE: begin
            wr_en     = 1'b1;
            wr_data   = MAT_EMPTY;
            grains_in = (&grains_ff) ? grains_ff : grains_ff + 16'd1;
            x_in      = at_right ? '0 : x_right;
            y_in      = at_right ? y_ff - YW'(1) : y_ff;
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_cell_in   = (cmd_ff.op == OP_READ) ? cell_ff : MAT_EMPTY;
               out_grains_in = (cmd_ff.op == OP_SWEEP) ? grains_ff : 16'd0;
            end
         end
         default: begin
         end
      endcase

      if (seed_load) begin
         lfsr_in = (seed_value == 16'd0) ? 16'd1 : seed_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         lfsr_ff      <= SEED_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         lfsr_ff      <= lfsr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      dir_ff        <= dir_in;
      grains_ff     <= grains_in;
      cell_ff       <= cell_in;
      out_cell_ff   <= out_cell_in;
      out_grains_ff <= out_grains_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/falling_sand_grid_step_top.sv -----
// Top level of the falling sand grid: register port, front end, queue and grid engine.
//
//  channel | direction | handshake            | payload
//  req_ch  | in        | valid / ready        | kind, x_pos, y_pos, material
//  rsp_ch  | out       | valid / ready        | cell_material, grains_moved
//  csr_*   | in        | APB psel / penable   | brush_size (0x0), random_seed (0x4)
//
// After reset a clearing pass writes every one of the 2**(clog2(W)+clog2(H)) cells (65536 at
// 256 x 256); req_ch.ready stays low until it ends. Paint writes the clipped box cell by cell,
// read fetches one cell, and a sweep scans every cell from row H-2 up to row 0, moving each
// sand grain down, or else diagonally, through the single write and read port of the cell
// memory. The result register frees the engine once taken.
`timescale 1ns / 1ps
module falling_sand_grid_step_top
   import fsg_pkg::*;
#(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   fsg_req_if.sink     req_ch,
   fsg_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]      brush_size_ff;
   logic [7:0]      brush_size_in;
   logic [15:0]     random_seed_ff;
   logic [15:0]     random_seed_in;
   logic            csr_write;
   logic            seed_load;
   back_status_type status;
   logic            push;
   cmd_type         push_cmd;
   logic            queue_full;
   logic            queue_not_empty;
   cmd_type         head_cmd;
   logic            pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seed_load  = csr_write && (csr_paddr[2] == CSR_RANDOM_SEED);
   assign csr_prdata = (csr_paddr[2] == CSR_RANDOM_SEED) ? {16'd0, random_seed_ff}
                                                         : {24'd0, brush_size_ff};

   always_comb begin
      brush_size_in  = brush_size_ff;
      random_seed_in = random_seed_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_BRUSH_SIZE:  brush_size_in  = csr_pwdata[7:0];
            CSR_RANDOM_SEED: random_seed_in = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brush_size_ff  <= BRUSH_RESET;
         random_seed_ff <= SEED_RESET;
      end else begin
         brush_size_ff  <= brush_size_in;
         random_seed_ff <= random_seed_in;
      end
   end

   fsg_front #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_front (
      .req_ch     (req_ch),
      .brush_size (brush_size_ff),
      .status     (status),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   fsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   fsg_back #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_not_empty),
      .cmd        (head_cmd),
      .pop        (pop),
      .seed_load  (seed_load),
      .seed_value (csr_pwdata[15:0]),
      .status     (status),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ----- hw/rtl/fsg_checker.sv -----
// Port-level checks on the falling sand grid top level, bound to it.
`timescale 1ns / 1ps
module fsg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_cell,
   input logic [15:0] rsp_grains,
   input logic        csr_pready
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_clear_blocks_items: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("items accepted during clearing pass");

   a_one_field_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell == 3'd0 || rsp_grains == 16'd0))
      else $error("read and sweep fields both nonzero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell) && $stable(rsp_grains))
      else $error("stalled result changed");

   a_pready_high: assert property (@(posedge clock)
      csr_pready)
      else $error("register port not ready");

endmodule

bind falling_sand_grid_step_top fsg_checker u_fsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_cell   (rsp_ch.cell_material),
   .rsp_grains (rsp_ch.grains_moved),
   .csr_pready (csr_pready)
);
